// ===== design/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared constants and the structs that travel along the frame cell chain.
// ----------------------------------------------------------------------------
package lrupr_pkg;

	// Table geometry.
	localparam int FRAMES    = 16;
	localparam int PAGE_BITS = 16;
	localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int AGE_W     = IDX_W;
	localparam int CFG_W     = 5;
	localparam int FRAME_W   = 4;
	localparam int EVICT_W   = 16;
	localparam int COUNT_W   = 32;

	localparam logic [AGE_W-1:0]   AGE_MAX   = AGE_W'(FRAMES - 1);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [AGE_W-1:0]     age_t;
	typedef logic [PAGE_BITS-1:0] page_t;

	// Search token that walks the chain, one cell per cycle.
	typedef struct packed {
		logic  valid;
		page_t page;
		logic  last;
		logic  hit;
		idx_t  hit_idx;
		age_t  hit_age;
		logic  empty_found;
		idx_t  empty_idx;
		idx_t  old_idx;
		age_t  old_age;
		page_t old_page;
	} pkt_t;

	// Update broadcast to all cells once the token leaves the chain.
	typedef struct packed {
		logic  en;
		logic  miss;
		idx_t  frame;
		age_t  limit;
		page_t page;
		logic  clear;
	} upd_t;

endpackage

// ===== design/lrupr_cell.sv =====
// ----------------------------------------------------------------------------
// LRU frame cell
// Holds one frame (valid, page, age rank), refines the search token as it
// passes, and applies the broadcast update at the end of a request.
// ----------------------------------------------------------------------------
module lrupr_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  lrupr_pkg::idx_t cell_idx,
	input  logic          in_use,
	input  lrupr_pkg::pkt_t pkt_in,
	input  lrupr_pkg::upd_t upd,
	output lrupr_pkg::pkt_t pkt_q
);
	import lrupr_pkg::*;

	logic  valid_q;
	page_t page_q;
	age_t  age_q;
	pkt_t  pkt_next;
	logic  is_target;
	logic  do_age;

	// Refine the token with this frame's contribution.
	always_comb begin
		pkt_next = pkt_in;
		if (pkt_in.valid && in_use) begin
			if (!pkt_in.hit && valid_q && page_q == pkt_in.page) begin
				pkt_next.hit     = 1'b1;
				pkt_next.hit_idx = cell_idx;
				pkt_next.hit_age = age_q;
			end
			if (!pkt_in.empty_found && !valid_q) begin
				pkt_next.empty_found = 1'b1;
				pkt_next.empty_idx   = cell_idx;
			end
			if (cell_idx == '0 || age_q > pkt_in.old_age) begin
				pkt_next.old_idx  = cell_idx;
				pkt_next.old_age  = age_q;
				pkt_next.old_page = page_q;
			end
		end
	end

	// Token register toward the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q <= '0;
		end else begin
			pkt_q <= pkt_next;
		end
	end

	// Age and fill decisions for the broadcast update.
	assign is_target = upd.en && in_use && (upd.frame == cell_idx);
	assign do_age    = upd.en && in_use && !is_target && valid_q &&
		(upd.miss || age_q < upd.limit) && (age_q != AGE_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			page_q  <= '0;
			age_q   <= '0;
		end else if (upd.en && upd.clear) begin
			valid_q <= 1'b0;
			page_q  <= '0;
			age_q   <= '0;
		end else if (is_target) begin
			age_q <= '0;
			if (upd.miss) begin
				valid_q <= 1'b1;
				page_q  <= upd.page;
			end
		end else if (do_age) begin
			age_q <= age_q + 1'b1;
		end
	end

endmodule

// ===== design/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement
// Fully associative frame table with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
// A request (page, last_request) is accepted at a rising edge where start is
// high and busy is low. The request then walks a chain of sixteen frame
// cells, one cell per cycle, collecting the hit frame, the first empty frame
// and the oldest frame. When it leaves the last cell, all cells update together
// and the registered result appears for exactly one cycle with result_strobe
// high. The receiver cannot stall; the result is taken in that cycle. busy
// drops during the result cycle, so the next request can be accepted there;
// no new request is taken while one is still in the cell chain.
// The frames_in_use register is written through cfg_valid/cfg_ready; a
// transfer is taken while the block is idle and no request is being started.
// Reset empties all frames, clears the fault count and sets frames_in_use
// to 16. A request with last_request set clears the table and the count
// after its result.
// ----------------------------------------------------------------------------
module lru_page_replacement (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [lrupr_pkg::PAGE_BITS-1:0] page,
	input  logic                           last_request,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lrupr_pkg::CFG_W-1:0]    cfg_data,
	output logic                           result_strobe,
	output logic                           hit,
	output logic [lrupr_pkg::FRAME_W-1:0]  frame,
	output logic                           evicted_valid,
	output logic [lrupr_pkg::EVICT_W-1:0]  evicted_page,
	output logic [lrupr_pkg::COUNT_W-1:0]  fault_count
);
	import lrupr_pkg::*;

	logic [CFG_W-1:0]   cfg_q;
	logic               busy_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_next;
	logic               accept;
	logic [FRAMES-1:0]  in_use;
	logic [FRAMES-1:0]  pkt_valids;
	pkt_t               head;
	pkt_t               tail;
	pkt_t               chain [FRAMES];
	upd_t               upd;
	idx_t               sel_frame;
	logic               is_evict;
	int unsigned        n_active;

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	// A request entering the chain must see one frame limit in every cell.
	assign cfg_ready = !busy_q && !start;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	// Active frame count: zero acts as one, large values clip to the table.
	always_comb begin
		n_active = 32'(cfg_q);
		if (n_active == 0) begin
			n_active = 1;
		end
		if (n_active > FRAMES) begin
			n_active = FRAMES;
		end
	end

	// Fresh token for a newly accepted request.
	always_comb begin
		head       = '0;
		head.valid = accept;
		head.page  = page;
		head.last  = last_request;
	end

	// The cell chain.
	for (genvar j = 0; j < FRAMES; j++) begin : g_cell
		assign in_use[j]     = (j < n_active);
		assign pkt_valids[j] = chain[j].valid;
		lrupr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(j)),
			.in_use   (in_use[j]),
			.pkt_in   ((j == 0) ? head : chain[(j == 0) ? 0 : j - 1]),
			.upd      (upd),
			.pkt_q    (chain[j])
		);
	end

	assign tail = chain[FRAMES-1];

	// Resolve the target frame and broadcast the update.
	always_comb begin
		is_evict  = !tail.hit && !tail.empty_found;
		sel_frame = tail.hit ? tail.hit_idx :
			(tail.empty_found ? tail.empty_idx : tail.old_idx);
		upd.en    = tail.valid;
		upd.miss  = !tail.hit;
		upd.frame = sel_frame;
		upd.limit = tail.hit_age;
		upd.page  = tail.page;
		upd.clear = tail.last;
		count_next = count_q;
		if (!tail.hit && count_q != COUNT_MAX) begin
			count_next = count_q + 1'b1;
		end
	end

	// Busy flag and fault count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.valid) begin
				busy_q <= 1'b0;
			end
			if (tail.valid) begin
				count_q <= tail.last ? '0 : count_next;
			end
		end
	end

	// Result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tail.valid) begin
			hit           <= tail.hit;
			frame         <= FRAME_W'(sel_frame);
			evicted_valid <= is_evict;
			evicted_page  <= is_evict ? EVICT_W'(tail.old_page) : '0;
			fault_count   <= count_next;
		end
	end

	// Only one request travels the chain at a time.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pkt_valids))
		else $error("more than one request token in the cell chain");

	// A token leaving the chain produces a result in the next cycle.
	a_tail_result: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |=> result_strobe)
		else $error("result strobe missing after token left the chain");

	// No request is accepted while a token is still in the chain.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(|pkt_valids) |-> busy_q)
		else $error("block not busy while a request is in flight");

	// An eviction only happens on a fault.
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && evicted_valid) |-> !hit)
		else $error("eviction reported on a hit");

endmodule
